@@ rtl/kci_pkg.sv @@
// Shared types and constants for the keyframe clip interpolator.
package kci_pkg;

  localparam int DEF_CLIP_SLOTS    = 16;
  localparam int DEF_KEYS_PER_CLIP = 16;
  localparam int NCOMP             = 9;
  localparam int COMP_W            = 32;
  localparam int IDX_W             = 5;
  localparam int OBJ_W             = 16;
  localparam int DIV_W             = 48;
  localparam int DIV_CNT_W         = 6;
  localparam int IN_DATA_W         = OBJ_W + 32 + NCOMP * COMP_W;
  localparam int OUT_FIELDS_W      = IDX_W + OBJ_W + NCOMP * COMP_W;
  localparam int OUT_DATA_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_CREATE_ONE  = 3'd0,
    OP_CREATE_LOOP = 3'd1,
    OP_ADD_KEY     = 3'd2,
    OP_PLAY        = 3'd3,
    OP_STOP        = 3'd4,
    OP_TICK        = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYWR,
    ST_TNEXT,
    ST_TSTART,
    ST_MDIV,
    ST_KRD,
    ST_KCMP,
    ST_FRAC,
    ST_FDIV,
    ST_CA,
    ST_CB,
    ST_CM,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/keyframe_clip_interpolator.sv @@
// Keyframe clip interpolator: clip table, key memories and a shared divide/lerp sequencer.
//
// A beat on the input stream is one command (tuser = operation). Create returns one beat at
// once with the new clip index, or CLIP_SLOTS when the table is full. Add key writes the key
// time and its nine components in turn; add key, play and stop return no beat.
// A tick walks the clips in index order, one clip at a time through a single sequencer: the
// elapsed update (plus a restoring divide when a looping clip with nonzero duration wraps),
// a key search that reads the key times one at a time, a second divide for the interpolation
// fraction when t1 exceeds t0, and the CA, CB, CM, MUL and ADD states through one multiplier
// for each of the nine lerps. The cost of a clip is set by the divider and the single read
// port of the key memories, plus any wait on the output register; a skipped clip only passes
// through ST_TNEXT. Each playing clip with two or more keys gives one beat, tlast on the
// final one. The input is not ready while a command is in work or a result beat is still
// waiting on the output register.
module keyframe_clip_interpolator
  import kci_pkg::*;
#(
  parameter int CLIP_SLOTS    = DEF_CLIP_SLOTS,
  parameter int KEYS_PER_CLIP = DEF_KEYS_PER_CLIP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target[15:0], time_value[47:16], pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
  // scl_x, scl_y, scl_z (32 bits each, from bit 48 up)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // clip_index[4:0], object_id[20:5], out_pos_x .. out_scl_z (32 bits each from bit 21),
  // zero fill at the top
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_of_run
  output logic                  out_tlast
);

  localparam int CW   = $clog2(CLIP_SLOTS + 1);
  localparam int SW   = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
  localparam int KCW  = $clog2(KEYS_PER_CLIP + 1);
  localparam int TDEP = CLIP_SLOTS * KEYS_PER_CLIP;
  localparam int TAW  = $clog2(TDEP);
  localparam int CDEP = TDEP * NCOMP;
  localparam int CAW  = $clog2(CDEP);

  // Clip table
  logic [CW-1:0]          clip_count_r;
  logic [OBJ_W-1:0]       clip_object_r   [CLIP_SLOTS];
  logic                   clip_looping_r  [CLIP_SLOTS];
  logic                   clip_playing_r  [CLIP_SLOTS];
  logic [KCW-1:0]         clip_key_cnt_r  [CLIP_SLOTS];
  logic [31:0]            clip_duration_r [CLIP_SLOTS];
  logic [31:0]            clip_elapsed_r  [CLIP_SLOTS];

  // Key memories
  logic [31:0]            time_mem [TDEP];
  logic [COMP_W-1:0]      comp_mem [CDEP];
  logic [31:0]            time_rd_r;
  logic [COMP_W-1:0]      comp_rd_r;
  logic [TAW-1:0]         time_ra;
  logic [CAW-1:0]         comp_ra;
  logic [CAW-1:0]         comp_wa;

  state_t                 state_r, state_nxt;

  // Command capture
  logic [SW-1:0]          tgt_r;
  logic [31:0]            tv_r;
  logic [COMP_W-1:0]      kin_r [NCOMP];
  logic [TAW-1:0]         kaddr_r;

  // Tick datapath
  logic [CW-1:0]          c_r;
  logic [TAW-1:0]         tbase_r;
  logic [31:0]            e_r;
  logic [KCW-1:0]         k_r;
  logic [31:0]            first_r, prev_r, t0_r, t1_r;
  logic [TAW-1:0]         ia_r, ib_r;
  logic                   neg_r;
  logic signed [31:0]     t_r;
  logic [3:0]             j_r;
  logic signed [31:0]     a_r, b_r;
  logic signed [64:0]     prod_r;
  logic [COMP_W-1:0]      res_r [NCOMP];

  // Shared restoring divider
  logic [DIV_W-1:0]       div_q_r;
  logic [31:0]            div_rem_r;
  logic [31:0]            div_den_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [32:0]            rem_sh;
  logic                   div_ge;
  logic [31:0]            rem_new;
  logic                   div_done;

  // Output register
  logic                   out_valid_r;
  logic [IDX_W-1:0]       oidx_r;
  logic [OBJ_W-1:0]       oobj_r;
  logic [COMP_W-1:0]      ocomp_r [NCOMP];
  logic                   olast_r;

  logic                   in_acc;
  op_t                    in_op;
  logic [OBJ_W-1:0]       in_target;
  logic                   tgt_ok;
  logic [SW-1:0]          tgt_idx;
  logic [SW-1:0]          c_idx;
  logic [CLIP_SLOTS-1:0]  elig_v;
  logic                   later_elig;
  logic [32:0]            e_sum;
  logic signed [32:0]     e_diff;
  logic [31:0]            e_mag;
  logic signed [49:0]     lerp_sum;
  logic [31:0]            lerp_sat;
  logic                   emit_go;

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign in_op      = op_t'(in_tuser);
  assign in_target  = in_tdata[OBJ_W-1:0];
  assign tgt_ok     = {{(OBJ_W > CW ? OBJ_W - CW : 0){1'b0}}, clip_count_r} > in_target;
  assign tgt_idx    = in_target[SW-1:0];
  assign c_idx      = c_r[SW-1:0];

  always_comb begin
    for (int i = 0; i < CLIP_SLOTS; i++) begin
      elig_v[i] = (CW'(i) < clip_count_r) && clip_playing_r[i] && (clip_key_cnt_r[i] >= KCW'(2));
    end
  end
  assign later_elig = |(elig_v >> (c_r + 1'b1));

  assign e_sum  = {1'b0, clip_elapsed_r[c_idx]} + {1'b0, tv_r};
  assign e_diff = $signed({1'b0, e_r}) - $signed({1'b0, t0_r});
  assign e_mag  = e_diff[32] ? 32'(-e_diff) : e_diff[31:0];

  // One divider step per cycle: shift in the next dividend bit, subtract when it fits.
  assign rem_sh   = {div_rem_r, div_q_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_r};
  assign rem_new  = div_ge ? 32'(rem_sh - {1'b0, div_den_r}) : rem_sh[31:0];
  assign div_done = div_cnt_r == DIV_CNT_W'(DIV_W - 1);

  // a + floor(prod / 65536), saturated
  assign lerp_sum = 50'(a_r) + 50'($signed(prod_r[64:16]));
  always_comb begin
    if (lerp_sum > 50'sh0_7FFF_FFFF) begin
      lerp_sat = 32'h7FFF_FFFF;
    end else if (lerp_sum < -50'sh0_8000_0000) begin
      lerp_sat = 32'h8000_0000;
    end else begin
      lerp_sat = lerp_sum[31:0];
    end
  end

  assign emit_go = !out_valid_r || out_tready;

  // Memory addresses
  always_comb begin
    time_ra = TAW'(tbase_r + TAW'(k_r));
    comp_ra = CAW'(ia_r * NCOMP + j_r);
    if (state_r == ST_CB) begin
      comp_ra = CAW'(ib_r * NCOMP + j_r);
    end
    comp_wa = CAW'(kaddr_r * NCOMP + j_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KEYWR) begin
      comp_mem[comp_wa] <= kin_r[j_r];
      if (j_r == 4'd0) begin
        time_mem[kaddr_r] <= tv_r;
      end
    end
    time_rd_r <= time_mem[time_ra];
    comp_rd_r <= comp_mem[comp_ra];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_ADD_KEY && tgt_ok &&
              clip_key_cnt_r[tgt_idx] < KCW'(KEYS_PER_CLIP)) begin
            state_nxt = ST_KEYWR;
          end else if (in_op == OP_TICK) begin
            state_nxt = ST_TNEXT;
          end
        end
      end
      ST_KEYWR:  if (j_r == 4'(NCOMP - 1)) state_nxt = ST_IDLE;
      ST_TNEXT: begin
        if (c_r >= clip_count_r) begin
          state_nxt = ST_IDLE;
        end else if (elig_v[c_idx]) begin
          state_nxt = ST_TSTART;
        end
      end
      ST_TSTART: begin
        if (e_sum > {1'b0, clip_duration_r[c_idx]} && clip_looping_r[c_idx] &&
            clip_duration_r[c_idx] != 32'd0) begin
          state_nxt = ST_MDIV;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_MDIV:   if (div_done) state_nxt = ST_KRD;
      ST_KRD:    state_nxt = ST_KCMP;
      ST_KCMP: begin
        if (k_r == '0) begin
          state_nxt = ST_KRD;
        end else if ((prev_r <= e_r && e_r <= time_rd_r) ||
                     k_r == clip_key_cnt_r[c_idx] - 1'b1) begin
          state_nxt = ST_FRAC;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_FRAC:   state_nxt = (t1_r > t0_r) ? ST_FDIV : ST_CA;
      ST_FDIV:   if (div_done) state_nxt = ST_CA;
      ST_CA:     state_nxt = ST_CB;
      ST_CB:     state_nxt = ST_CM;
      ST_CM:     state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = (j_r == 4'(NCOMP - 1)) ? ST_EMIT : ST_CA;
      ST_EMIT:   if (emit_go) state_nxt = ST_TNEXT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Clip table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_count_r <= '0;
      for (int i = 0; i < CLIP_SLOTS; i++) begin
        clip_playing_r[i]  <= 1'b0;
        clip_key_cnt_r[i]  <= '0;
        clip_duration_r[i] <= '0;
        clip_elapsed_r[i]  <= '0;
      end
    end else begin
      if (in_acc) begin
        case (in_op)
          OP_CREATE_ONE, OP_CREATE_LOOP: begin
            if (clip_count_r < CW'(CLIP_SLOTS)) begin
              clip_playing_r[clip_count_r[SW-1:0]]  <= 1'b0;
              clip_key_cnt_r[clip_count_r[SW-1:0]]  <= '0;
              clip_duration_r[clip_count_r[SW-1:0]] <= '0;
              clip_elapsed_r[clip_count_r[SW-1:0]]  <= '0;
              clip_count_r <= clip_count_r + 1'b1;
            end
          end
          OP_PLAY: begin
            if (tgt_ok) begin
              clip_playing_r[tgt_idx] <= 1'b1;
              clip_elapsed_r[tgt_idx] <= '0;
            end
          end
          OP_STOP: begin
            if (tgt_ok) clip_playing_r[tgt_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_r == ST_KEYWR && j_r == 4'd0) begin
        clip_key_cnt_r[tgt_r] <= clip_key_cnt_r[tgt_r] + 1'b1;
        if (tv_r > clip_duration_r[tgt_r]) clip_duration_r[tgt_r] <= tv_r;
      end
      if (state_r == ST_TSTART) begin
        if (e_sum > {1'b0, clip_duration_r[c_idx]}) begin
          if (clip_looping_r[c_idx]) begin
            // Zero duration wraps to zero; otherwise the divider fills this in.
            clip_elapsed_r[c_idx] <= '0;
          end else begin
            clip_elapsed_r[c_idx] <= clip_duration_r[c_idx];
            clip_playing_r[c_idx] <= 1'b0;
          end
        end else begin
          clip_elapsed_r[c_idx] <= e_sum[31:0];
        end
      end
      if (state_r == ST_MDIV && div_done) begin
        clip_elapsed_r[c_idx] <= rem_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_CREATE_ONE || in_op == OP_CREATE_LOOP) &&
        clip_count_r < CW'(CLIP_SLOTS)) begin
      clip_object_r[clip_count_r[SW-1:0]]  <= in_target;
      clip_looping_r[clip_count_r[SW-1:0]] <= in_op == OP_CREATE_LOOP;
    end
  end

  // Output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (in_op == OP_CREATE_ONE || in_op == OP_CREATE_LOOP)) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_EMIT && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        j_r     <= '0;
        c_r     <= '0;
        tgt_r   <= tgt_idx;
        tv_r    <= in_tdata[OBJ_W +: 32];
        kaddr_r <= TAW'(tgt_idx * KEYS_PER_CLIP + clip_key_cnt_r[tgt_idx]);
        for (int i = 0; i < NCOMP; i++) begin
          kin_r[i] <= in_tdata[OBJ_W + 32 + i * COMP_W +: COMP_W];
        end
        if (in_acc && (in_op == OP_CREATE_ONE || in_op == OP_CREATE_LOOP)) begin
          oidx_r  <= (clip_count_r < CW'(CLIP_SLOTS)) ? IDX_W'(clip_count_r)
                                                      : IDX_W'(CLIP_SLOTS);
          oobj_r  <= in_target;
          olast_r <= 1'b1;
          for (int i = 0; i < NCOMP; i++) ocomp_r[i] <= '0;
        end
      end
      ST_KEYWR: j_r <= j_r + 1'b1;
      ST_TNEXT: begin
        tbase_r <= TAW'(c_idx * KEYS_PER_CLIP);
        k_r     <= '0;
        j_r     <= '0;
        if (!(c_r >= clip_count_r) && !elig_v[c_idx]) c_r <= c_r + 1'b1;
      end
      ST_TSTART: begin
        if (e_sum > {1'b0, clip_duration_r[c_idx]}) begin
          e_r <= clip_looping_r[c_idx] ? 32'd0 : clip_duration_r[c_idx];
        end else begin
          e_r <= e_sum[31:0];
        end
        div_q_r   <= DIV_W'(e_sum);
        div_rem_r <= '0;
        div_den_r <= clip_duration_r[c_idx];
        div_cnt_r <= '0;
      end
      ST_MDIV, ST_FDIV: begin
        div_q_r   <= {div_q_r[DIV_W-2:0], div_ge};
        div_rem_r <= rem_new;
        div_cnt_r <= div_cnt_r + 1'b1;
        if (state_r == ST_MDIV && div_done) e_r <= rem_new;
        if (state_r == ST_FDIV && div_done) begin
          if (neg_r) begin
            t_r <= (({div_q_r[DIV_W-2:0], div_ge}) > DIV_W'(33'h0_8000_0000))
                   ? 32'sh8000_0000 : 32'(-{div_q_r[30:0], div_ge});
          end else begin
            t_r <= (({div_q_r[DIV_W-2:0], div_ge}) > DIV_W'(32'h7FFF_FFFF))
                   ? 32'sh7FFF_FFFF : {div_q_r[30:0], div_ge};
          end
        end
      end
      ST_KCMP: begin
        if (k_r == '0) begin
          first_r <= time_rd_r;
          prev_r  <= time_rd_r;
          k_r     <= k_r + 1'b1;
        end else if (prev_r <= e_r && e_r <= time_rd_r) begin
          ia_r <= TAW'(tbase_r + TAW'(k_r) - 1'b1);
          ib_r <= TAW'(tbase_r + TAW'(k_r));
          t0_r <= prev_r;
          t1_r <= time_rd_r;
        end else if (k_r == clip_key_cnt_r[c_idx] - 1'b1) begin
          ia_r <= tbase_r;
          ib_r <= TAW'(tbase_r + TAW'(k_r));
          t0_r <= first_r;
          t1_r <= time_rd_r;
        end else begin
          prev_r <= time_rd_r;
          k_r    <= k_r + 1'b1;
        end
      end
      ST_FRAC: begin
        t_r       <= '0;
        neg_r     <= e_diff[32];
        div_q_r   <= {e_mag, 16'h0000};
        div_rem_r <= '0;
        div_den_r <= 32'(t1_r - t0_r);
        div_cnt_r <= '0;
      end
      ST_CB:  a_r <= comp_rd_r;
      ST_CM:  b_r <= comp_rd_r;
      ST_MUL: prod_r <= (33'(b_r) - 33'(a_r)) * 65'(t_r);
      ST_ADD: begin
        res_r[j_r] <= lerp_sat;
        j_r        <= j_r + 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          oidx_r  <= IDX_W'(c_r);
          oobj_r  <= clip_object_r[c_idx];
          olast_r <= !later_elig;
          for (int i = 0; i < NCOMP; i++) ocomp_r[i] <= res_r[i];
          c_r     <= c_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[IDX_W-1:0]           = oidx_r;
    out_tdata[IDX_W +: OBJ_W]      = oobj_r;
    for (int i = 0; i < NCOMP; i++) begin
      out_tdata[IDX_W + OBJ_W + i * COMP_W +: COMP_W] = ocomp_r[i];
    end
  end

  // Input only becomes ready when the output register is free.
  a_ready_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input ready while a result beat waits");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    clip_count_r <= CW'(CLIP_SLOTS)) else $error("clip count beyond table size");

  a_create_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_CREATE_ONE || in_tuser == OP_CREATE_LOOP))
    |=> (out_tvalid && out_tlast)) else $error("create gave no single result beat");

endmodule
